FILE: hw/rtl/assert_macros.svh
// Assertion helpers used by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, quiet while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/ptt_pkg.sv
`timescale 1ns / 1ps

package ptt_pkg;

  // Field widths
  localparam int TIME_W   = 32;
  localparam int MODE_W   = 2;
  localparam int SLOT_W   = 4;
  localparam int MASK_W   = 16;
  localparam int STATUS_W = 2;

  // Defaults
  localparam int              DEF_MAX_TASKS  = 16;
  localparam logic [TIME_W-1:0] MAX_PERIOD_RST = 32'd86400000;

  typedef logic [MODE_W-1:0]   mode_t;
  typedef logic [STATUS_W-1:0] status_t;

  // Command codes
  localparam mode_t MODE_ADD    = 2'd0;
  localparam mode_t MODE_REMOVE = 2'd1;
  localparam mode_t MODE_TICK   = 2'd2;

  // Result status codes
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_TOO_LARGE = 2'd1;
  localparam status_t ST_FULL      = 2'd2;
  localparam status_t ST_BAD_INDEX = 2'd3;

endpackage

FILE: hw/rtl/ptt_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port, registered read.
module ptt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/periodic_task_table_unit.sv
`timescale 1ns / 1ps

// Channel  | direction | handshake            | payload
// ---------+-----------+----------------------+-------------------------------------------
// in_      | in        | in_valid / in_ready   | in_mode, in_period_ms, in_slot_index, in_now_ms
// out_     | out       | out_valid / out_ready | out_fire_mask, out_added_slot, out_status
// cfg_     | in        | cfg_wr_en (no wait)   | cfg_wr_data -> max_period
//
// Add and error words pass from accept through S_FIN to the result registers; a tick walks
// the entries in S_TICK and a remove shifts those above slot_index down in S_SHIFT, one
// entry per cycle through the single read port of the task RAM. One word is in flight
// at a time; the next is taken while the last result still waits on out_ready.
// rst_n is synchronous: it empties the table and restores max_period; the RAM
// itself is not cleared, as no entry at or above the count is ever read.
module periodic_task_table_unit import ptt_pkg::*; #(
  parameter int MAX_TASKS = DEF_MAX_TASKS
) (
  input  logic              clk,
  input  logic              rst_n,
  // command words
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [MODE_W-1:0] in_mode,
  input  logic [TIME_W-1:0] in_period_ms,
  input  logic [SLOT_W-1:0] in_slot_index,
  input  logic [TIME_W-1:0] in_now_ms,
  // result words
  output logic              out_valid,
  input  logic              out_ready,
  output logic [MASK_W-1:0] out_fire_mask,
  output logic [SLOT_W-1:0] out_added_slot,
  output logic [STATUS_W-1:0] out_status,
  // configuration
  input  logic              cfg_wr_en,
  input  logic [TIME_W-1:0] cfg_wr_data
);

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
  localparam int ENT_W = 2 * TIME_W;

  typedef enum logic [1:0] {S_IDLE, S_TICK, S_SHIFT, S_FIN} state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [TIME_W-1:0]   max_period_r, max_period_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [TIME_W-1:0]   now_r, now_nxt;
  logic [MASK_W-1:0]   res_mask_r, res_mask_nxt;
  logic [SLOT_W-1:0]   res_slot_r, res_slot_nxt;
  status_t             res_status_r, res_status_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [MASK_W-1:0]   out_mask_r, out_mask_nxt;
  logic [SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  status_t             out_status_r, out_status_nxt;

  // RAM port signals; entry = {period, last_run}
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [ENT_W-1:0]    ram_wdata;
  logic [IDX_W-1:0]    ram_raddr;
  logic [ENT_W-1:0]    ram_rdata;

  logic                in_acc;
  logic [TIME_W-1:0]   rd_period;
  logic [TIME_W-1:0]   rd_last;
  logic [TIME_W-1:0]   elapsed;
  logic                fire;
  logic [CNT_W-1:0]    idx_inc;
  logic                more;
  logic                slot_bad;
  logic [CNT_W-1:0]    slot_inc;

  ptt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_TASKS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  // fire test on the entry read last cycle
  assign rd_period = ram_rdata[ENT_W-1:TIME_W];
  assign rd_last   = ram_rdata[TIME_W-1:0];
  assign elapsed   = now_r - rd_last;
  assign fire      = rd_period < elapsed;

  // walk pointer
  assign idx_inc  = CNT_W'(idx_r) + CNT_W'(1);
  assign more     = idx_inc < count_r;
  assign slot_bad = CMP_W'(in_slot_index) >= CMP_W'(count_r);
  assign slot_inc = CNT_W'(in_slot_index) + CNT_W'(1);

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    max_period_nxt = cfg_wr_en ? cfg_wr_data : max_period_r;
    idx_nxt        = idx_r;
    now_nxt        = now_r;
    res_mask_nxt   = res_mask_r;
    res_slot_nxt   = res_slot_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_mask_nxt   = out_mask_r;
    out_slot_nxt   = out_slot_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    ram_waddr      = idx_r;
    ram_wdata      = ram_rdata;
    ram_raddr      = IDX_W'(idx_inc);

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_mask_nxt   = '0;
          res_slot_nxt   = '0;
          res_status_nxt = ST_OK;
          state_nxt      = S_FIN;
          case (in_mode)
            MODE_ADD: begin
              if (in_period_ms > max_period_r) begin
                res_status_nxt = ST_TOO_LARGE;
              end else if (count_r == CNT_W'(MAX_TASKS)) begin
                res_status_nxt = ST_FULL;
              end else begin
                ram_we       = 1'b1;
                ram_waddr    = IDX_W'(count_r);
                ram_wdata    = {in_period_ms, {TIME_W{1'b0}}};
                res_slot_nxt = SLOT_W'(count_r);
                count_nxt    = count_r + CNT_W'(1);
              end
            end
            MODE_REMOVE: begin
              if (slot_bad) begin
                res_status_nxt = ST_BAD_INDEX;
              end else if (slot_inc == count_r) begin
                // last slot: nothing to shift
                count_nxt = count_r - CNT_W'(1);
              end else begin
                ram_raddr = IDX_W'(slot_inc);
                idx_nxt   = IDX_W'(slot_inc);
                state_nxt = S_SHIFT;
              end
            end
            MODE_TICK: begin
              now_nxt = in_now_ms;
              if (count_r != '0) begin
                ram_raddr = '0;
                idx_nxt   = '0;
                state_nxt = S_TICK;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_TICK: begin
        if (fire) begin
          ram_we       = 1'b1;
          ram_waddr    = idx_r;
          ram_wdata    = {rd_period, now_r};
          res_mask_nxt = res_mask_r | (MASK_W'(1) << idx_r);
        end
        if (more) begin
          idx_nxt = IDX_W'(idx_inc);
        end else begin
          state_nxt = S_FIN;
        end
      end

      S_SHIFT: begin
        // move entry idx down by one
        ram_we    = 1'b1;
        ram_waddr = idx_r - IDX_W'(1);
        ram_wdata = ram_rdata;
        if (more) begin
          idx_nxt = IDX_W'(idx_inc);
        end else begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_mask_nxt   = res_mask_r;
          out_slot_nxt   = res_slot_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      max_period_r <= MAX_PERIOD_RST;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      max_period_r <= max_period_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    idx_r        <= idx_nxt;
    now_r        <= now_nxt;
    res_mask_r   <= res_mask_nxt;
    res_slot_r   <= res_slot_nxt;
    res_status_r <= res_status_nxt;
    out_mask_r   <= out_mask_nxt;
    out_slot_r   <= out_slot_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_fire_mask  = out_mask_r;
  assign out_added_slot = out_slot_r;
  assign out_status     = out_status_r;

endmodule

FILE: hw/rtl/ptt_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Port-level checks for the task table.
module ptt_port_checker import ptt_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [MASK_W-1:0]   out_fire_mask,
  input logic [SLOT_W-1:0]   out_added_slot,
  input logic [STATUS_W-1:0] out_status
);

  // stalled result word holds
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_fire_mask) && $stable(out_added_slot) && $stable(out_status))

  // after reset: empty output, ready for a command
  `ASSERT_NEXT_ALWAYS(a_reset_idle, clk, !rst_n, !out_valid && in_ready)

  // one command at a time: ready drops once a word is taken
  `ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)

  // an error result carries no slot and no fire bits
  `ASSERT_SAME(a_error_blank, clk, rst_n, out_valid && (out_status != ST_OK), (out_added_slot == '0) && (out_fire_mask == '0))

endmodule

bind periodic_task_table_unit ptt_port_checker u_ptt_checker (.*);
